// ===== rtl/tts_pkg.sv =====
// ---------------------------------------------------------------------------
// tts_pkg
// Types and operation codes for the task time-share profiler.
// ---------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned TIME_W = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_SWITCH    = 3'd0;
  localparam logic [OP_W-1:0] OP_WINDOW    = 3'd1;
  localparam logic [OP_W-1:0] OP_START     = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_TASK = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_INST = 3'd5;

  // one request
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  index;
    logic [TIME_W-1:0] timer_value;
  } tts_req_t;

  // one response
  typedef struct packed {
    logic [TIME_W-1:0] read_value;
    logic              index_invalid;
  } tts_rsp_t;

  // operands for the shared accumulate unit
  typedef struct packed {
    logic [TIME_W-1:0] acc;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] now;
  } tts_alu_op_t;

endpackage

// ===== rtl/tts_alu.sv =====
// ---------------------------------------------------------------------------
// tts_alu
// Shared accumulate unit: sum = acc + (base - now), wrapping at 16 bits,
// registered for the write-back cycle.
// ---------------------------------------------------------------------------
module tts_alu
  import tts_pkg::*;
(
  input  logic              clk_i,
  input  logic              load_i,
  input  tts_alu_op_t       op_i,
  output logic [TIME_W-1:0] sum_o
);

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] sum_d;
  logic [TIME_W-1:0] sum_q;

  // elapsed time of a down-counting timer, then charge it
  assign elapsed = op_i.base - op_i.now;
  assign sum_d   = op_i.acc + elapsed;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/task_time_share_profiler.sv =====
// Sequence: a taken request is registered, the shared unit is loaded in the
// calculate state, a window end then sweeps the stores, publishing one task and one
// instance entry per cycle, and the write state registers the result, waiting while
// an earlier result is held. A new request is taken only back in the idle state.
// Reset (asynchronous, active low) clears all counters and stores at once.
// ---------------------------------------------------------------------------
// task_time_share_profiler
// Run-time statistics per task and per measured code section, with a
// sequencer around one shared accumulate unit.
// ---------------------------------------------------------------------------
module task_time_share_profiler
  import tts_pkg::*;
#(
  parameter int unsigned NUM_TASKS     = 16,
  parameter int unsigned NUM_INSTANCES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tts_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tts_rsp_t out_data_o
);

  localparam int unsigned TaskAw   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned InstAw   = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;
  localparam int unsigned SweepLen = (NUM_TASKS > NUM_INSTANCES) ? NUM_TASKS : NUM_INSTANCES;
  localparam int unsigned CntW     = (SweepLen > 1) ? $clog2(SweepLen) : 1;
  localparam logic [CntW-1:0] SweepLast = CntW'(SweepLen - 1);

  // sequencer states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCalc  = 2'd1;
  localparam logic [1:0] StSweep = 2'd2;
  localparam logic [1:0] StWrite = 2'd3;

  logic [1:0]        state_d, state_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  tts_req_t          req_q;
  logic              out_valid_q;
  tts_rsp_t          out_q;
  tts_rsp_t          rsp;

  logic [TIME_W-1:0] task_acc_q  [NUM_TASKS];
  logic [TIME_W-1:0] task_snap_q [NUM_TASKS];
  logic [TIME_W-1:0] inst_start_q[NUM_INSTANCES];
  logic [TIME_W-1:0] inst_acc_q  [NUM_INSTANCES];
  logic [TIME_W-1:0] inst_work_q [NUM_INSTANCES];
  logic [TIME_W-1:0] last_sw_q;

  logic              in_fire;
  logic              write_fire;
  logic              sweep;
  logic              task_ok;
  logic              inst_ok;
  logic              sweep_task_ok;
  logic              sweep_inst_ok;
  logic [TaskAw-1:0] task_addr;
  logic [InstAw-1:0] inst_addr;
  tts_alu_op_t       alu_op;
  logic [TIME_W-1:0] alu_sum;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign write_fire = (state_q == StWrite) && (!out_valid_q || out_ready_i);
  assign sweep      = (state_q == StSweep);

  // index range checks
  assign task_ok       = ({1'b0, req_q.index} < (IDX_W + 1)'(NUM_TASKS));
  assign inst_ok       = ({1'b0, req_q.index} < (IDX_W + 1)'(NUM_INSTANCES));
  assign sweep_task_ok = ({1'b0, cnt_q} < (CntW + 1)'(NUM_TASKS));
  assign sweep_inst_ok = ({1'b0, cnt_q} < (CntW + 1)'(NUM_INSTANCES));

  // one address per store: sweep counter or request index
  assign task_addr = sweep ? cnt_q[TaskAw-1:0] : req_q.index[TaskAw-1:0];
  assign inst_addr = sweep ? cnt_q[InstAw-1:0] : req_q.index[InstAw-1:0];

  // request register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        cnt_d = '0;
        if (req_q.operation == OP_WINDOW) begin
          state_d = StSweep;
        end else begin
          state_d = StWrite;
        end
      end
      StSweep: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SweepLast) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        if (write_fire) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // operand select for the shared unit
  always_comb begin
    alu_op.now = req_q.timer_value;
    if (req_q.operation == OP_STOP) begin
      alu_op.acc  = inst_acc_q[inst_addr];
      alu_op.base = inst_start_q[inst_addr];
    end else begin
      alu_op.acc  = task_acc_q[task_addr];
      alu_op.base = last_sw_q;
    end
  end

  tts_alu u_alu (
    .clk_i  (clk_i),
    .load_i (state_q == StCalc),
    .op_i   (alu_op),
    .sum_o  (alu_sum)
  );

  // statistics stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        task_acc_q[i]  <= '0;
        task_snap_q[i] <= '0;
      end
      for (int i = 0; i < NUM_INSTANCES; i++) begin
        inst_start_q[i] <= '0;
        inst_acc_q[i]   <= '0;
        inst_work_q[i]  <= '0;
      end
      last_sw_q <= '0;
    end else begin
      // window end: publish and clear one task and one instance entry per cycle
      if (sweep) begin
        if (sweep_task_ok) begin
          task_snap_q[task_addr] <= task_acc_q[task_addr];
          task_acc_q[task_addr]  <= '0;
        end
        if (sweep_inst_ok) begin
          inst_work_q[inst_addr] <= inst_acc_q[inst_addr];
          inst_acc_q[inst_addr]  <= '0;
        end
      end
      // write back of single-entry operations
      if (write_fire) begin
        case (req_q.operation)
          OP_SWITCH: begin
            if (task_ok) begin
              task_acc_q[task_addr] <= alu_sum;
            end
            last_sw_q <= req_q.timer_value;
          end
          OP_START: begin
            if (inst_ok) begin
              inst_start_q[inst_addr] <= req_q.timer_value;
            end
          end
          OP_STOP: begin
            if (inst_ok) begin
              inst_acc_q[inst_addr] <= alu_sum;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // response
  always_comb begin
    rsp.read_value    = '0;
    rsp.index_invalid = 1'b0;
    if ((req_q.operation == OP_READ_TASK) && task_ok) begin
      rsp.read_value = task_snap_q[task_addr];
    end
    if ((req_q.operation == OP_READ_INST) && inst_ok) begin
      rsp.read_value = inst_work_q[inst_addr];
    end
    if ((req_q.operation inside {OP_START, OP_STOP, OP_READ_INST}) && !inst_ok) begin
      rsp.index_invalid = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (write_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_fire) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/tts_check.sv =====
// ---------------------------------------------------------------------------
// tts_check
// Port-level checks of the task time-share profiler, bound to the top level.
// ---------------------------------------------------------------------------
module tts_check
  import tts_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input tts_req_t in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tts_rsp_t out_data_o
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // the block is busy right after taking a request
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // no result appears in the cycle after a request
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // a flagged index never returns data
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.index_invalid |-> out_data_o.read_value == '0)
    else $error("invalid index returned data");

  // no fresh result is handed over in the cycle after a request
  a_req_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !(out_valid_o && out_ready_i && $rose(out_valid_o)))
    else $error("result handed over in the cycle after a request");

  logic unused_req;
  assign unused_req = ^in_data_i;

endmodule

bind task_time_share_profiler tts_check u_tts_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
